### rtl/prbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prbc_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int SLOT_OVERHEAD = 4;
    localparam int ADDR_W        = $clog2(MEM_BYTES);
    localparam int SUM_W         = ADDR_W + 3;
    localparam int HK_W          = $clog2(SLOT_OVERHEAD);

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_WALK   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_VERDICT = 2'd3;

    localparam logic [1:0] VERD_END    = 2'd1;
    localparam logic [1:0] VERD_DELETE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_WALK_END = 3'd3;
    localparam logic [2:0] ST_PHASE    = 3'd4;

    localparam logic       CFG_HDR_LEN  = 1'b0;
    localparam logic       CFG_CAPACITY = 1'b1;

    localparam logic [7:0] DELETED_FLAG = 8'h01;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       last;
        logic [1:0] verdict;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic        last_byte;
        logic        in_header;
        logic [12:0] item_length;
        logic [10:0] record_count;
        logic [12:0] used_bytes;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/packed_record_buffer_compactor.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Payload
// in        input      i_in_valid / o_in_ready        i_in_item  (prbc_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready      o_out_item (prbc_pkg::t_out_item)
// cfg       input      i_cfg_we                       i_cfg_index, i_cfg_data
// A new item is taken only once the last one is answered; after the final appended byte
// the slot header bytes are written, and a walk start or advancing verdict reads the next
// item length. A walk that deleted records ends with compaction, which reads each record's
// length and flag, then copies each live record through the single memory port pair.
// Reset is synchronous; the record memory is not cleared. A full output register
// holds the block in its response state until the item is taken.

module packed_record_buffer_compactor (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  prbc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output prbc_pkg::t_out_item  o_out_item,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire [12:0]           i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_HDR   = 10'b0000000010,
        S_LD_LO = 10'b0000000100,
        S_LD_HI = 10'b0000001000,
        S_C_TOP = 10'b0000010000,
        S_C_LO  = 10'b0000100000,
        S_C_HI  = 10'b0001000000,
        S_C_FL  = 10'b0010000000,
        S_CP_RD = 10'b0100000000,
        S_CP_WR = 10'b1000000000
    } t_state;

    logic [7:0] r_mem [prbc_pkg::MEM_BYTES];
    logic [7:0] r_mem_q;
    logic       r_rd_oob;

    t_state                  r_state, n_state;
    logic                    r_resp, n_resp;
    logic [7:0]              r_hdr_len;
    logic [12:0]             r_cap;
    logic [12:0]             r_used, n_used;
    logic [10:0]             r_live, n_live;
    logic [12:0]             r_start, n_start;
    logic [12:0]             r_fill, n_fill;
    logic [12:0]             r_cursor, n_cursor;
    logic [12:0]             r_off, n_off;
    logic                    r_walk, n_walk;
    logic                    r_anyd, n_anyd;
    logic [12:0]             r_cur_ilen, n_cur_ilen;
    logic [7:0]              r_ilo, n_ilo;
    logic [2:0]              r_status, n_status;
    logic                    r_rb_en, n_rb_en;
    logic                    r_lastb, n_lastb;
    logic                    r_inhdr, n_inhdr;
    logic [12:0]             r_ilen_out, n_ilen_out;
    logic [prbc_pkg::HK_W-1:0] r_hk, n_hk;
    logic [12:0]             r_src, n_src;
    logic [12:0]             r_dst, n_dst;
    logic [12:0]             r_span, n_span;
    logic [12:0]             r_k, n_k;
    logic                    r_out_valid;
    prbc_pkg::t_out_item     r_out;

    logic                         mem_we, mem_re;
    logic [prbc_pkg::SUM_W-1:0]   mem_wa, mem_ra;
    logic [7:0]                   mem_wd, rdata;
    logic                         accept, cfg_ok, out_load;
    logic [prbc_pkg::SUM_W-1:0]   cap_lim, pos, rec_end, next_cur, cmp_span;
    logic [12:0]                  app_start, fill_inc, app_ilen, body, remain, cmp_ilen;

    assign rdata      = r_rd_oob ? 8'd0 : r_mem_q;
    assign o_in_ready = (r_state == S_IDLE) && !r_resp;
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = r_resp && (!r_out_valid || i_out_ready);
    assign cfg_ok     = (r_used == 13'd0) && (r_fill == 13'd0) && !r_walk;

    assign cap_lim   = (prbc_pkg::SUM_W'(r_cap) > prbc_pkg::SUM_W'(prbc_pkg::MEM_BYTES))
                       ? prbc_pkg::SUM_W'(prbc_pkg::MEM_BYTES) : prbc_pkg::SUM_W'(r_cap);
    assign app_start = (r_fill == 13'd0) ? r_used : r_start;
    assign pos       = prbc_pkg::SUM_W'(app_start) + prbc_pkg::SUM_W'(prbc_pkg::SLOT_OVERHEAD)
                       + prbc_pkg::SUM_W'(r_fill);
    assign fill_inc  = (r_fill <= 13'(prbc_pkg::MEM_BYTES)) ? r_fill + 13'd1 : r_fill;
    assign app_ilen  = (fill_inc > {5'd0, r_hdr_len}) ? fill_inc - {5'd0, r_hdr_len} : 13'd0;
    assign rec_end   = prbc_pkg::SUM_W'(app_start) + prbc_pkg::SUM_W'(prbc_pkg::SLOT_OVERHEAD)
                       + prbc_pkg::SUM_W'(fill_inc);
    assign body      = {5'd0, r_hdr_len} + r_cur_ilen;
    assign next_cur  = prbc_pkg::SUM_W'(r_cursor) + prbc_pkg::SUM_W'(prbc_pkg::SLOT_OVERHEAD)
                       + prbc_pkg::SUM_W'(r_hdr_len) + prbc_pkg::SUM_W'(r_cur_ilen);
    assign remain    = r_used - r_src;

    assign cmp_ilen = r_cur_ilen;
    assign cmp_span = prbc_pkg::SUM_W'(prbc_pkg::SLOT_OVERHEAD) + prbc_pkg::SUM_W'(r_hdr_len)
                      + prbc_pkg::SUM_W'(cmp_ilen);

    always_comb begin
        n_state    = r_state;
        n_resp     = r_resp;
        n_used     = r_used;
        n_live     = r_live;
        n_start    = r_start;
        n_fill     = r_fill;
        n_cursor   = r_cursor;
        n_off      = r_off;
        n_walk     = r_walk;
        n_anyd     = r_anyd;
        n_cur_ilen = r_cur_ilen;
        n_ilo      = r_ilo;
        n_status   = r_status;
        n_rb_en    = r_rb_en;
        n_lastb    = r_lastb;
        n_inhdr    = r_inhdr;
        n_ilen_out = r_ilen_out;
        n_hk       = r_hk;
        n_src      = r_src;
        n_dst      = r_dst;
        n_span     = r_span;
        n_k        = r_k;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = 8'd0;
        mem_re     = 1'b0;
        mem_ra     = '0;
        if (out_load) begin
            n_resp = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status   = prbc_pkg::ST_OK;
                    n_rb_en    = 1'b0;
                    n_lastb    = 1'b0;
                    n_inhdr    = 1'b0;
                    n_ilen_out = 13'd0;
                    n_resp     = 1'b1;
                    unique case (i_in_item.command)
                        prbc_pkg::CMD_APPEND: begin
                            if (r_walk) begin
                                n_status = prbc_pkg::ST_PHASE;
                            end else begin
                                n_start = app_start;
                                mem_we  = (pos < cap_lim);
                                mem_wa  = pos;
                                mem_wd  = i_in_item.data_byte;
                                n_fill  = fill_inc;
                                if (i_in_item.last) begin
                                    n_fill = 13'd0;
                                    if (rec_end > cap_lim) begin
                                        n_status = prbc_pkg::ST_OVERFLOW;
                                    end else if (app_ilen == 13'd0) begin
                                        n_status = prbc_pkg::ST_EMPTY;
                                    end else begin
                                        n_used     = rec_end[12:0];
                                        n_live     = r_live + 11'd1;
                                        n_ilen_out = app_ilen;
                                        n_hk       = '0;
                                        n_resp     = 1'b0;
                                        n_state    = S_HDR;
                                    end
                                end
                            end
                        end
                        prbc_pkg::CMD_WALK: begin
                            if (r_walk || r_fill != 13'd0) begin
                                n_status = prbc_pkg::ST_PHASE;
                            end else if (r_used == 13'd0) begin
                                n_status = prbc_pkg::ST_WALK_END;
                                n_anyd   = 1'b0;
                                n_cursor = 13'd0;
                                n_off    = 13'd0;
                            end else begin
                                n_walk   = 1'b1;
                                n_anyd   = 1'b0;
                                n_cursor = 13'd0;
                                n_off    = 13'd0;
                                mem_re   = 1'b1;
                                mem_ra   = '0;
                                n_resp   = 1'b0;
                                n_state  = S_LD_LO;
                            end
                        end
                        prbc_pkg::CMD_READ: begin
                            if (!r_walk) begin
                                n_status = prbc_pkg::ST_PHASE;
                            end else begin
                                n_ilen_out = r_cur_ilen;
                                if (r_off >= body) begin
                                    n_status = prbc_pkg::ST_PHASE;
                                end else begin
                                    mem_re  = 1'b1;
                                    mem_ra  = prbc_pkg::SUM_W'(r_cursor)
                                              + prbc_pkg::SUM_W'(prbc_pkg::SLOT_OVERHEAD)
                                              + prbc_pkg::SUM_W'(r_off);
                                    n_rb_en = 1'b1;
                                    n_lastb = (r_off + 13'd1 == body);
                                    n_inhdr = (r_off < {5'd0, r_hdr_len});
                                    n_off   = r_off + 13'd1;
                                end
                            end
                        end
                        prbc_pkg::CMD_VERDICT: begin
                            if (!r_walk) begin
                                n_status = prbc_pkg::ST_PHASE;
                            end else begin
                                if (i_in_item.verdict == prbc_pkg::VERD_DELETE) begin
                                    mem_we = (prbc_pkg::SUM_W'(r_cursor) + prbc_pkg::SUM_W'(2)
                                              < prbc_pkg::SUM_W'(prbc_pkg::MEM_BYTES));
                                    mem_wa = prbc_pkg::SUM_W'(r_cursor) + prbc_pkg::SUM_W'(2);
                                    mem_wd = prbc_pkg::DELETED_FLAG;
                                    if (r_live != 11'd0) begin
                                        n_live = r_live - 11'd1;
                                    end
                                    n_anyd = 1'b1;
                                end
                                n_off = 13'd0;
                                if (i_in_item.verdict == prbc_pkg::VERD_END
                                    || next_cur >= prbc_pkg::SUM_W'(r_used)) begin
                                    n_status = prbc_pkg::ST_WALK_END;
                                    n_walk   = 1'b0;
                                    n_cursor = 13'd0;
                                    if (r_anyd || i_in_item.verdict == prbc_pkg::VERD_DELETE)
                                    begin
                                        n_anyd  = 1'b0;
                                        n_src   = 13'd0;
                                        n_dst   = 13'd0;
                                        n_resp  = 1'b0;
                                        n_state = S_C_TOP;
                                    end
                                end else begin
                                    n_cursor = next_cur[12:0];
                                    mem_re   = 1'b1;
                                    mem_ra   = next_cur;
                                    n_resp   = 1'b0;
                                    n_state  = S_LD_LO;
                                end
                            end
                        end
                        default: begin
                            n_status = prbc_pkg::ST_PHASE;
                        end
                    endcase
                end
            end
            S_HDR: begin
                mem_we = 1'b1;
                mem_wa = prbc_pkg::SUM_W'(r_start) + prbc_pkg::SUM_W'(r_hk);
                if (r_hk == '0) begin
                    mem_wd = r_ilen_out[7:0];
                end else if (r_hk == prbc_pkg::HK_W'(1)) begin
                    mem_wd = {3'd0, r_ilen_out[12:8]};
                end else begin
                    mem_wd = 8'd0;
                end
                n_hk = r_hk + prbc_pkg::HK_W'(1);
                if (r_hk == prbc_pkg::HK_W'(prbc_pkg::SLOT_OVERHEAD - 1)) begin
                    n_resp  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LD_LO: begin
                n_ilo  = rdata;
                mem_re = 1'b1;
                mem_ra = prbc_pkg::SUM_W'(r_cursor) + prbc_pkg::SUM_W'(1);
                n_state = S_LD_HI;
            end
            S_LD_HI: begin
                n_cur_ilen = {rdata[4:0], r_ilo};
                n_ilen_out = {rdata[4:0], r_ilo};
                n_resp     = 1'b1;
                n_state    = S_IDLE;
            end
            S_C_TOP: begin
                if (r_src < r_used) begin
                    mem_re  = 1'b1;
                    mem_ra  = prbc_pkg::SUM_W'(r_src);
                    n_state = S_C_LO;
                end else begin
                    n_used  = r_dst;
                    n_resp  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_C_LO: begin
                n_ilo   = rdata;
                mem_re  = 1'b1;
                mem_ra  = prbc_pkg::SUM_W'(r_src) + prbc_pkg::SUM_W'(1);
                n_state = S_C_HI;
            end
            S_C_HI: begin
                n_cur_ilen = {rdata[4:0], r_ilo};
                mem_re     = 1'b1;
                mem_ra     = prbc_pkg::SUM_W'(r_src) + prbc_pkg::SUM_W'(2);
                n_state    = S_C_FL;
            end
            S_C_FL: begin
                n_span = (cmp_span > prbc_pkg::SUM_W'(remain)) ? remain : cmp_span[12:0];
                n_k    = 13'd0;
                if ((rdata & prbc_pkg::DELETED_FLAG) != 8'd0) begin
                    n_src   = r_src + ((cmp_span > prbc_pkg::SUM_W'(remain))
                                       ? remain : cmp_span[12:0]);
                    n_state = S_C_TOP;
                end else begin
                    n_state = S_CP_RD;
                end
            end
            S_CP_RD: begin
                if (r_k < r_span) begin
                    mem_re  = 1'b1;
                    mem_ra  = prbc_pkg::SUM_W'(r_src) + prbc_pkg::SUM_W'(r_k);
                    n_state = S_CP_WR;
                end else begin
                    n_src   = r_src + r_span;
                    n_dst   = r_dst + r_span;
                    n_state = S_C_TOP;
                end
            end
            S_CP_WR: begin
                mem_we  = 1'b1;
                mem_wa  = prbc_pkg::SUM_W'(r_dst) + prbc_pkg::SUM_W'(r_k);
                mem_wd  = rdata;
                n_k     = r_k + 13'd1;
                n_state = S_CP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && mem_wa < prbc_pkg::SUM_W'(prbc_pkg::MEM_BYTES)) begin
            r_mem[mem_wa[prbc_pkg::ADDR_W-1:0]] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q  <= r_mem[mem_ra[prbc_pkg::ADDR_W-1:0]];
            r_rd_oob <= (mem_ra >= prbc_pkg::SUM_W'(prbc_pkg::MEM_BYTES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_resp      <= 1'b0;
            r_hdr_len   <= 8'd0;
            r_cap       <= 13'd4096;
            r_used      <= 13'd0;
            r_live      <= 11'd0;
            r_start     <= 13'd0;
            r_fill      <= 13'd0;
            r_cursor    <= 13'd0;
            r_off       <= 13'd0;
            r_walk      <= 1'b0;
            r_anyd      <= 1'b0;
            r_cur_ilen  <= 13'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_resp     <= n_resp;
            r_used     <= n_used;
            r_live     <= n_live;
            r_start    <= n_start;
            r_fill     <= n_fill;
            r_cursor   <= n_cursor;
            r_off      <= n_off;
            r_walk     <= n_walk;
            r_anyd     <= n_anyd;
            r_cur_ilen <= n_cur_ilen;
            if (i_cfg_we && cfg_ok) begin
                if (i_cfg_index == prbc_pkg::CFG_HDR_LEN) begin
                    r_hdr_len <= i_cfg_data[7:0];
                end else begin
                    r_cap <= i_cfg_data;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ilo      <= n_ilo;
        r_status   <= n_status;
        r_rb_en    <= n_rb_en;
        r_lastb    <= n_lastb;
        r_inhdr    <= n_inhdr;
        r_ilen_out <= n_ilen_out;
        r_hk       <= n_hk;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_span     <= n_span;
        r_k        <= n_k;
        if (out_load) begin
            r_out.status       <= r_status;
            r_out.read_byte    <= r_rb_en ? rdata : 8'd0;
            r_out.last_byte    <= r_lastb;
            r_out.in_header    <= r_inhdr;
            r_out.item_length  <= r_ilen_out;
            r_out.record_count <= r_live;
            r_out.used_bytes   <= r_used;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
